@@ sv/phase_current_sample_filter_macros.svh @@
// Assertion helpers for the phase current sample filter.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PHASE_CURRENT_SAMPLE_FILTER_MACROS_SVH
`define PHASE_CURRENT_SAMPLE_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PCSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PCSF_ASSERT_IMP(lbl, ante, cons, msg)
`define PCSF_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

@@ sv/pcsf_pkg.sv @@
package pcsf_pkg;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int SMP_W    = 12;
  localparam int RING_W   = SMP_W + 1;
  localparam int FRAC_W   = 16;
  localparam int VAL_W    = 29;
  localparam int DIFF_W   = VAL_W + 1;
  localparam int MA_W     = 19;
  localparam int WCOUNT_W = 7;
  localparam int DEC_W    = 4;

  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [SMP_W-1:0]         sample_t;
  typedef logic [RING_W-1:0]        ring_word_t;
  typedef logic [VAL_W-1:0]         value_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [MA_W-1:0]   ma_t;
  typedef logic [WCOUNT_W-1:0]      wcount_t;
  typedef logic [DEC_W-1:0]         decade_t;

  // Commands
  localparam cmd_t CMD_SAMPLE_A = 2'd0;
  localparam cmd_t CMD_SAMPLE_B = 2'd1;
  localparam cmd_t CMD_CAL      = 2'd2;
  localparam cmd_t CMD_MIRROR   = 2'd3;

  localparam value_t  VALUE_MAX    = {VAL_W{1'b1}};
  localparam decade_t DECADE       = 4'd10;
  localparam wcount_t WINDOW_RESET = 7'd10;

  localparam int RING_DEPTH_DEF     = 64;
  localparam int FILTER_DIVISOR_DEF = 16;

  // Current scaling: |diff| * 10000 / (538 * 2^16) == (|diff| * 625 / 2^13) / 269.
  // The divide by 269 is a reciprocal multiply, exact for 26-bit operands.
  localparam int MA_NUM_W      = 10;
  localparam logic [MA_NUM_W-1:0] MA_NUM = 10'd625;
  localparam int MA_PRE_SHIFT  = 13;
  localparam int MA_RECIP_W    = 27;
  localparam logic [MA_RECIP_W-1:0] MA_RECIP = 27'd127731370;  // ceil(2^35 / 269)
  localparam int MA_POST_SHIFT = 35;
  localparam int MA_Q_W        = 18;
  localparam int MA_P1_W       = VAL_W + MA_NUM_W;
  localparam int MA_T_W        = MA_P1_W - MA_PRE_SHIFT;
  localparam int MA_P2_W       = MA_T_W + MA_RECIP_W;

endpackage

@@ sv/pcsf_if.sv @@
interface pcsf_in_if import pcsf_pkg::*;;
  logic    valid;
  logic    ready;
  cmd_t    cmd;
  sample_t sample;
  logic    transistor_a_on;

  modport source (output valid, cmd, sample, transistor_a_on, input ready);
  modport sink   (input valid, cmd, sample, transistor_a_on, output ready);
endinterface

interface pcsf_out_if import pcsf_pkg::*;;
  logic   valid;
  logic   ready;
  value_t filtered_value;
  diff_t  offset_difference;
  ma_t    phase_current_ma;
  logic   value_updated;

  modport source (output valid, filtered_value, offset_difference, phase_current_ma,
                  value_updated, input ready);
  modport sink   (input valid, filtered_value, offset_difference, phase_current_ma,
                  value_updated, output ready);
endinterface

interface pcsf_cfg_if import pcsf_pkg::*;;
  logic    valid;
  logic    ready;
  wcount_t window_count;

  modport source (output valid, window_count, input ready);
  modport sink   (input valid, window_count, output ready);
endinterface

@@ sv/phase_current_sample_filter.sv @@
// Channel   Dir  Handshake            Payload
// in_req    in   valid/ready          cmd, sample, transistor_a_on
// out_rsp   out  valid/ready          filtered_value, offset_difference,
//                                     phase_current_ma, value_updated
// cfg_wr    in   valid/ready (ready=1) window_count
//
// Sequence: an accepted request runs the current scaling, then the output load; an update
// first runs n steps, n being window_count clamped to 1..RING_DEPTH, and the next request is
// taken back in idle. Each update step is one ring read plus one multiply/accumulate pass.
// Reset: no clearing pass; unwritten ring slots read as zero through a fill mark.
// Stalls: a result stalled on out_rsp holds in the output register; the sequencer waits
// in its load state only when a second result is ready before the first has left.
`include "phase_current_sample_filter_macros.svh"

module phase_current_sample_filter import pcsf_pkg::*; #(
  parameter int RING_DEPTH     = RING_DEPTH_DEF,
  parameter int FILTER_DIVISOR = FILTER_DIVISOR_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pcsf_in_if.sink    in_req,
  pcsf_out_if.source out_rsp,
  pcsf_cfg_if.sink   cfg_wr
);

  // Ring and counter widths
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int CMP_W = (CNT_W > WCOUNT_W) ? CNT_W : WCOUNT_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

  // x / FILTER_DIVISOR as (x * DIV_M) >> DIV_S, exact for any 29-bit x
  localparam int DIV_L  = $clog2(FILTER_DIVISOR);
  localparam int DIV_S  = VAL_W + DIV_L;
  localparam int PROD_W = 2 * VAL_W + DIV_L + 1;
  localparam logic [VAL_W:0] DIV_M =
    (VAL_W + 1)'(((64'd1 << DIV_S) + 64'(FILTER_DIVISOR) - 64'd1) / 64'(FILTER_DIVISOR));

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FRD    = 3'd1;  // issue first ring read
  localparam logic [2:0] ST_FMUL   = 3'd2;  // divide-by-W products, prefetch next slot
  localparam logic [2:0] ST_FACC   = 3'd3;  // fold into filter state
  localparam logic [2:0] ST_SCALE1 = 3'd4;  // |diff| * 625
  localparam logic [2:0] ST_SCALE2 = 3'd5;  // reciprocal of 269
  localparam logic [2:0] ST_LOAD   = 3'd6;  // load output register

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] write_index_r;
  logic             wrapped_r;
  decade_t          decade_r;
  value_t           filter_state_r;
  value_t           offset_level_r;
  wcount_t          window_count_r;
  logic [IDX_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] steps_left_r;
  logic             out_valid_r;

  // Ring memory
  ring_word_t ring_mem [RING_DEPTH];
  ring_word_t ring_rdata_r;
  logic       rd_hit_r;
  logic       ring_we;
  logic       ring_re;

  // Datapath registers
  logic [PROD_W-1:0]  prod_v_r;
  logic [PROD_W-1:0]  prod_s_r;
  logic [MA_P1_W-1:0] ma_p1_r;
  logic [MA_P2_W-1:0] ma_p2_r;
  logic               neg_r;
  logic               updated_r;
  value_t             out_value_r;
  diff_t              out_diff_r;
  ma_t                out_ma_r;
  logic               out_updated_r;

  logic              in_acc;
  logic              do_store;
  decade_t           decade_inc;
  decade_t           decade_next_val;
  logic              run_update;
  logic [IDX_W-1:0]  write_index_inc;
  logic [IDX_W-1:0]  newest_slot;
  logic [IDX_W-1:0]  rd_ptr_dec;
  logic [CMP_W-1:0]  wc_ext;
  logic [CNT_W-1:0]  window_steps;
  logic signed [VAL_W+1:0] mirror_raw;
  value_t            mirror_val;
  value_t            samp_q, val_q;
  logic [VAL_W+1:0]  fold_sum;
  value_t            fold_val;
  diff_t             diff_now;
  value_t            diff_mag;
  logic [MA_Q_W-1:0] ma_q;
  ma_t               ma_mag;
  logic              out_load;
  ring_word_t        fold_sample;

  assign in_acc        = in_req.valid && in_req.ready;
  assign in_req.ready  = (state_r == ST_IDLE);
  assign cfg_wr.ready  = 1'b1;

  // Keep a channel A sample while transistor A is off, a channel B sample while it is on
  assign do_store = in_acc &&
                    (((in_req.cmd == CMD_SAMPLE_A) && !in_req.transistor_a_on) ||
                     ((in_req.cmd == CMD_SAMPLE_B) && in_req.transistor_a_on));

  assign decade_inc      = (decade_r == DECADE - 4'd1) ? '0 : decade_r + 4'd1;
  assign decade_next_val = do_store ? decade_inc : decade_r;
  assign run_update      = (in_req.cmd == CMD_SAMPLE_A) && (decade_next_val == '0);

  assign write_index_inc = (write_index_r == IDX_LAST) ? '0 : write_index_r + 1'b1;
  // Newest slot: the one just before the write pointer after this request's store
  assign newest_slot     = do_store ? write_index_r
                         : ((write_index_r == '0) ? IDX_LAST : write_index_r - 1'b1);
  assign rd_ptr_dec      = (rd_ptr_r == '0) ? IDX_LAST : rd_ptr_r - 1'b1;

  // Clamp the window to 1..RING_DEPTH
  assign wc_ext = CMP_W'(window_count_r);
  always_comb begin
    if (window_count_r == '0) begin
      window_steps = CNT_W'(1);
    end else if (wc_ext > CMP_W'(RING_DEPTH)) begin
      window_steps = CNT_W'(RING_DEPTH);
    end else begin
      window_steps = CNT_W'(wc_ext);
    end
  end

  // Mirror: 2*offset - value, saturated to the value range
  assign mirror_raw = $signed({1'b0, offset_level_r, 1'b0}) - $signed({2'b00, filter_state_r});
  always_comb begin
    if (mirror_raw < 0) begin
      mirror_val = '0;
    end else if (mirror_raw > $signed({2'b00, VALUE_MAX})) begin
      mirror_val = VALUE_MAX;
    end else begin
      mirror_val = mirror_raw[VAL_W-1:0];
    end
  end

  // Fold: value - value/W + sample/W, saturated
  assign fold_sample = rd_hit_r ? ring_rdata_r : '0;
  assign val_q       = prod_v_r[DIV_S +: VAL_W];
  assign samp_q      = prod_s_r[DIV_S +: VAL_W];
  assign fold_sum    = {2'b00, filter_state_r} - {2'b00, val_q} + {2'b00, samp_q};
  assign fold_val    = (fold_sum > {2'b00, VALUE_MAX}) ? VALUE_MAX : fold_sum[VAL_W-1:0];

  // Offset difference and its magnitude
  assign diff_now = $signed({1'b0, offset_level_r}) - $signed({1'b0, filter_state_r});
  assign diff_mag = diff_now[DIFF_W-1] ? VAL_W'(-diff_now) : VAL_W'(diff_now);
  assign ma_q     = ma_p2_r[MA_POST_SHIFT +: MA_Q_W];
  assign ma_mag   = $signed({1'b0, ma_q});

  assign out_load = (state_r == ST_LOAD) && (!out_valid_r || out_rsp.ready);

  assign ring_we = do_store;
  assign ring_re = (state_r == ST_FRD) || (state_r == ST_FMUL);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = run_update ? ST_FRD : ST_SCALE1;
        end
      end
      ST_FRD:    state_nxt = ST_FMUL;
      ST_FMUL:   state_nxt = ST_FACC;
      ST_FACC:   state_nxt = (steps_left_r == CNT_W'(1)) ? ST_SCALE1 : ST_FMUL;
      ST_SCALE1: state_nxt = ST_SCALE2;
      ST_SCALE2: state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      write_index_r  <= '0;
      wrapped_r      <= 1'b0;
      decade_r       <= '0;
      filter_state_r <= '0;
      offset_level_r <= '0;
      window_count_r <= WINDOW_RESET;
      rd_ptr_r       <= '0;
      steps_left_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr.valid && cfg_wr.ready) begin
        window_count_r <= cfg_wr.window_count;
      end
      if (do_store) begin
        write_index_r <= write_index_inc;
        if (write_index_r == IDX_LAST) begin
          wrapped_r <= 1'b1;
        end
      end
      if (in_acc) begin
        decade_r     <= decade_next_val;
        rd_ptr_r     <= newest_slot;
        steps_left_r <= window_steps;
        case (in_req.cmd)
          CMD_CAL:    offset_level_r <= filter_state_r;
          CMD_MIRROR: filter_state_r <= mirror_val;
          default:    ;
        endcase
      end
      if (ring_re) begin
        rd_ptr_r <= rd_ptr_dec;
      end
      if (state_r == ST_FACC) begin
        filter_state_r <= fold_val;
        steps_left_r   <= steps_left_r - 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[write_index_r] <= {in_req.sample, 1'b0};
    end
    if (ring_re) begin
      ring_rdata_r <= ring_mem[rd_ptr_r];
      rd_hit_r     <= wrapped_r || (rd_ptr_r < write_index_r);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      updated_r <= run_update;
    end
    if (state_r == ST_FMUL) begin
      prod_v_r <= PROD_W'(filter_state_r) * PROD_W'(DIV_M);
      prod_s_r <= PROD_W'({fold_sample, {FRAC_W{1'b0}}}) * PROD_W'(DIV_M);
    end
    if (state_r == ST_SCALE1) begin
      neg_r   <= diff_now[DIFF_W-1];
      ma_p1_r <= MA_P1_W'(diff_mag) * MA_P1_W'(MA_NUM);
    end
    if (state_r == ST_SCALE2) begin
      ma_p2_r <= MA_P2_W'(ma_p1_r[MA_PRE_SHIFT +: MA_T_W]) * MA_P2_W'(MA_RECIP);
    end
    if (out_load) begin
      out_value_r   <= filter_state_r;
      out_diff_r    <= diff_now;
      out_ma_r      <= neg_r ? -ma_mag : ma_mag;
      out_updated_r <= updated_r;
    end
  end

  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.filtered_value    = out_value_r;
  assign out_rsp.offset_difference = out_diff_r;
  assign out_rsp.phase_current_ma  = out_ma_r;
  assign out_rsp.value_updated     = out_updated_r;

  `PCSF_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_r != ST_IDLE,
                   "accepted request left sequencer idle")
  `PCSF_ASSERT_NXT(a_cal_captures, in_acc && (in_req.cmd == CMD_CAL),
                   offset_level_r == $past(filter_state_r),
                   "calibrate did not capture filter value")
  `PCSF_ASSERT_IMP(a_fold_count, state_r == ST_FMUL,
                   (steps_left_r != '0) && (steps_left_r <= CNT_W'(RING_DEPTH)),
                   "fold step count out of range")
  `PCSF_ASSERT_IMP(a_decade_range, 1'b1, decade_r < DECADE, "decade counter out of range")

endmodule

@@ tb/sv/phase_current_sample_filter_checker.sv @@
`timescale 1ns / 1ps

module phase_current_sample_filter_checker import pcsf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  pcsf_in_if   in_mon,
  pcsf_out_if  out_mon,
  pcsf_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   result_count,
  output int   update_count
);

  typedef struct packed {
    value_t filtered;
    diff_t  diff;
    ma_t    ma;
    logic   updated;
  } filter_result_t;

  // Shadow copy of the filter state
  ring_word_t     sample_ring [RING_DEPTH_DEF];
  int             wr_slot;
  int             kept_mod10;
  value_t         filt_level;
  value_t         offset_level;
  wcount_t        window_len;
  filter_result_t expected_q [$];

  // Fold the newest window_len ring entries into the filter, newest slot first.
  function automatic void fold_newest();
    int     n;
    int     slot;
    longint acc;
    n = int'(window_len);
    if (n == 0) n = 1;
    if (n > RING_DEPTH_DEF) n = RING_DEPTH_DEF;
    for (int i = 0; i < n; i++) begin
      slot = (wr_slot + 2 * RING_DEPTH_DEF - 1 - i) % RING_DEPTH_DEF;
      acc  = longint'(filt_level);
      acc  = acc - acc / FILTER_DIVISOR_DEF;
      acc  = acc + (longint'(sample_ring[slot]) << FRAC_W) / FILTER_DIVISOR_DEF;
      if (acc > longint'(VALUE_MAX)) acc = longint'(VALUE_MAX);
      filt_level = acc[VAL_W-1:0];
    end
  endfunction

  function automatic void store_kept(sample_t s);
    sample_ring[wr_slot] = {s, 1'b0};
    wr_slot    = (wr_slot + 1) % RING_DEPTH_DEF;
    kept_mod10 = (kept_mod10 + 1) % int'(DECADE);
  endfunction

  function automatic filter_result_t predict_request(cmd_t c, sample_t s, logic a_on);
    filter_result_t r;
    longint         d;
    longint         mag;
    longint         m;
    r.updated = 1'b0;
    case (c)
      CMD_SAMPLE_A: begin
        if (!a_on) store_kept(s);
        if (kept_mod10 == 0) begin
          fold_newest();
          r.updated = 1'b1;
        end
      end
      CMD_SAMPLE_B: begin
        if (a_on) store_kept(s);
      end
      CMD_CAL: begin
        offset_level = filt_level;
      end
      CMD_MIRROR: begin
        m = 2 * longint'(offset_level) - longint'(filt_level);
        if (m < 0) m = 0;
        if (m > longint'(VALUE_MAX)) m = longint'(VALUE_MAX);
        filt_level = m[VAL_W-1:0];
      end
      default: ;
    endcase
    d   = longint'(offset_level) - longint'(filt_level);
    mag = (d < 0) ? -d : d;
    mag = (mag * 10000) / (538 * 65536);
    m   = (d < 0) ? -mag : mag;
    r.filtered = filt_level;
    r.diff     = d[DIFF_W-1:0];
    r.ma       = m[MA_W-1:0];
    return r;
  endfunction

  function automatic void report_field(string name, longint want, longint got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    filter_result_t got;
    filter_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH_DEF; i++) sample_ring[i] = '0;
      wr_slot      = 0;
      kept_mod10   = 0;
      filt_level   = '0;
      offset_level = '0;
      window_len   = WINDOW_RESET;
      expected_q.delete();
      fail_count   = 0;
      pending      = 0;
      result_count = 0;
      update_count = 0;
    end else begin
      // retire first: a result leaving now never belongs to a request entering now
      if (out_mon.valid && out_mon.ready) begin
        got.filtered = out_mon.filtered_value;
        got.diff     = out_mon.offset_difference;
        got.ma       = out_mon.phase_current_ma;
        got.updated  = out_mon.value_updated;
        result_count++;
        if (got.updated) update_count++;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no request pending, expected none, got value %0d",
                   $time, got.filtered);
        end else begin
          want = expected_q.pop_front();
          report_field("filtered_value", longint'(want.filtered), longint'(got.filtered));
          report_field("offset_difference", longint'($signed(want.diff)),
                       longint'($signed(got.diff)));
          report_field("phase_current_ma", longint'($signed(want.ma)),
                       longint'($signed(got.ma)));
          report_field("value_updated", longint'(want.updated), longint'(got.updated));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) window_len = cfg_mon.window_count;
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(predict_request(in_mon.cmd, in_mon.sample,
                                             in_mon.transistor_a_on));
      pending = expected_q.size();
    end
  end

endmodule

@@ tb/sv/phase_current_sample_filter_tb.sv @@
`timescale 1ns / 1ps

module phase_current_sample_filter_tb;
  import pcsf_pkg::*;

  // Random request budget, spread over the window phases below; bursts run past
  // each phase's share by about thirty requests on average.
  localparam int RANDOM_REQS  = 1630;
  localparam int PHASES       = 7;
  // Long receiver hold-off, well past the time the sequencer needs to back up.
  localparam int HOLD_CYCLES  = 400;
  // Allow the longest update, a full-depth window, plus margin after the last result.
  localparam int DRAIN_CYCLES = 2 * RING_DEPTH_DEF + 16;
  // Worst case: ~1850 requests, each with the longest update and the longest sender and
  // receiver gaps; take that several times over.
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pcsf_in_if  in_req();
  pcsf_out_if out_rsp();
  pcsf_cfg_if cfg_wr();

  int     fail_count;
  int     pending;
  int     result_count;
  int     update_count;
  int     req_count    = 0;
  int     cfg_count    = 0;
  longint cycle_count  = 0;
  bit     idle_en      = 1'b1;  // clear for stretches with no gaps on either side
  bit     hold_off_req = 1'b0;  // set by stimulus, cleared by the result sink

  phase_current_sample_filter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  phase_current_sample_filter_checker result_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_req),
    .out_mon      (out_rsp),
    .cfg_mon      (cfg_wr),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .update_count (update_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Gap length: mostly back to back, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 48);
  endfunction

  // Bias toward the rails so both ends of the ADC range show up often.
  function automatic sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return sample_t'($urandom_range(0, 4095));
  endfunction

  // Drop valid for gap n, scrambling the payload so the block must ignore it.
  task automatic idle_input(int n);
    if (n > 0) begin
      @(negedge clk);
      in_req.valid           <= 1'b0;
      in_req.cmd             <= cmd_t'($urandom_range(0, 3));
      in_req.sample          <= sample_t'($urandom_range(0, 4095));
      in_req.transistor_a_on <= 1'($urandom_range(0, 1));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offer one request, hold it until accepted, then take a random gap.
  task automatic send_request(cmd_t c, sample_t s, logic a_on);
    @(negedge clk);
    in_req.valid           <= 1'b1;
    in_req.cmd             <= c;
    in_req.sample          <= s;
    in_req.transistor_a_on <= a_on;
    do @(posedge clk); while (!(in_req.valid && in_req.ready));
    req_count++;
    idle_input(pick_gap());
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    idle_input(1);
    while (pending != 0) @(posedge clk);
  endtask

  // Write the window length; only called with the block idle.
  task automatic write_window(wcount_t w);
    drain();
    @(negedge clk);
    cfg_wr.valid        <= 1'b1;
    cfg_wr.window_count <= w;
    do @(posedge clk); while (!(cfg_wr.valid && cfg_wr.ready));
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
    cfg_count++;
  endtask

  // PWM-like traffic: both channels sampled each period, transistor toggling now and then.
  task automatic pwm_burst();
    int   n;
    logic a_on;
    n    = $urandom_range(4, 30);
    a_on = 1'($urandom_range(0, 1));
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) a_on = ~a_on;
      if ($urandom_range(0, 1) == 0) begin
        send_request(CMD_SAMPLE_A, pick_sample(), a_on);
        send_request(CMD_SAMPLE_B, pick_sample(), a_on);
      end else begin
        send_request(CMD_SAMPLE_B, pick_sample(), a_on);
        send_request(CMD_SAMPLE_A, pick_sample(), a_on);
      end
    end
  endtask

  // Settle at one level, calibrate, move to another level, then mirror.
  // Rail-to-rail swings drive the mirror into both saturation limits.
  task automatic level_swing();
    sample_t lvl_cal;
    sample_t lvl_mir;
    int      n;
    case ($urandom_range(0, 2))
      0: begin lvl_cal = '1; lvl_mir = '0; end
      1: begin lvl_cal = '0; lvl_mir = '1; end
      default: begin lvl_cal = pick_sample(); lvl_mir = pick_sample(); end
    endcase
    n = $urandom_range(20, 60);
    repeat (n) send_request(CMD_SAMPLE_A, lvl_cal, 1'b0);
    send_request(CMD_CAL, pick_sample(), 1'($urandom_range(0, 1)));
    repeat (n) send_request(CMD_SAMPLE_A, lvl_mir, 1'b0);
    send_request(CMD_MIRROR, pick_sample(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 1) == 0)
      send_request(CMD_MIRROR, pick_sample(), 1'($urandom_range(0, 1)));
  endtask

  // Unstructured requests: any command, any payload.
  task automatic noise_burst();
    repeat ($urandom_range(1, 10))
      send_request(cmd_t'($urandom_range(0, 3)), sample_t'($urandom_range(0, 4095)),
                   1'($urandom_range(0, 1)));
  endtask

  // Result sink: random backpressure, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // hold ready low long enough for the output register and sequencer to back up
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      gap = pick_gap();
      if (gap == 0) begin
        out_rsp.ready <= 1'b1;
      end else begin
        out_rsp.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    wcount_t window_plan [PHASES];
    int      phase_end;
    int      mid;
    int      r;
    bit      paused;

    in_req.valid           = 1'b0;
    in_req.cmd             = CMD_SAMPLE_A;
    in_req.sample          = '0;
    in_req.transistor_a_on = 1'b0;
    cfg_wr.valid           = 1'b0;
    cfg_wr.window_count    = WINDOW_RESET;

    // Hold reset low from the start, then release it on a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, window at its reset value.
    // A event with the transistor on right after reset: no write, but the
    // kept count is zero, so the filter still runs over an all-zero window.
    send_request(CMD_SAMPLE_A, 12'hABC, 1'b1);
    // B event with the transistor off: dropped.
    send_request(CMD_SAMPLE_B, '1, 1'b0);
    // B event with the transistor on: kept, count goes to one, never an update.
    send_request(CMD_SAMPLE_B, '1, 1'b1);
    // Eight more kept full-scale A samples, then the tenth triggers an update.
    repeat (8) send_request(CMD_SAMPLE_A, '1, 1'b0);
    send_request(CMD_SAMPLE_A, '1, 1'b0);
    // Calibrate with a nonzero sample that must be ignored.
    send_request(CMD_CAL, '1, 1'b1);
    // A event with the transistor on and count not at zero: nothing happens.
    send_request(CMD_SAMPLE_B, '0, 1'b1);
    send_request(CMD_SAMPLE_A, '0, 1'b1);
    // Mirror right at the offset is a no-op.
    send_request(CMD_MIRROR, 12'h555, 1'b0);
    // Pull the value down with an update on the ninth zero, then mirror it above the offset.
    repeat (9) send_request(CMD_SAMPLE_A, '0, 1'b0);
    send_request(CMD_MIRROR, 12'hAAA, 1'b1);

    // Random part: one window setting per phase, extremes and out-of-range values first.
    window_plan = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd3, 7'd0};
    window_plan[PHASES-1] = wcount_t'($urandom_range(0, 127));
    for (int p = 0; p < PHASES; p++) begin
      write_window(window_plan[p]);
      // turn off gaps for a couple of phases to run back to back
      idle_en   = (p != 2) && (p != 5);
      phase_end = req_count + RANDOM_REQS / PHASES;
      mid       = req_count + RANDOM_REQS / (2 * PHASES);
      paused    = 1'b0;

      if (p == 2) begin
        // stall the receiver and keep offering until the input backs up
        hold_off_req = 1'b1;
        repeat (30)
          send_request(cmd_t'($urandom_range(0, 1)), pick_sample(),
                       1'($urandom_range(0, 1)));
      end

      while (req_count < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 60) pwm_burst();
        else if (r < 75) level_swing();
        else noise_burst();
        if (p == 4 && !paused && req_count >= mid) begin
          // pause the sender until every result is back, then resume
          drain();
          paused = 1'b1;
        end
      end
    end

    // Let the last results out, then give the block its worst update time to misbehave.
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d requests over %0d window settings, all four commands and both",
             req_count, cfg_count + 1);
    $display("transistor states; %0d results compared, %0d of them filter updates.",
             result_count, update_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
